// File: rtl/spa_pkg.sv
// spa_pkg: shared constants, types and the exponent coefficient table
// for the sparse pair affinity unit. No dependencies.

package spa_pkg;

	localparam int MAX_POINTS    = 1024;
	localparam int MAX_DIM       = 16;
	localparam int MAX_NEIGHBORS = 64;

	localparam int PT_W    = $clog2(MAX_POINTS);
	localparam int DIM_W   = $clog2(MAX_DIM);
	localparam int CNT_W   = $clog2(MAX_NEIGHBORS) + 1;
	localparam int SLOT_W  = 6;
	localparam int COORD_W = 16;
	localparam int BETA_W  = 32;
	localparam int NORM_W  = 32;
	localparam int RAD_W   = 40;
	localparam int DIST_W  = 40;
	localparam int AFF_W   = 32;
	localparam int TOT_W   = 48;
	localparam int EXP_W   = 33;
	localparam int T_W     = 21;
	localparam int K_W     = 5;

	// configuration register widths and indexes
	localparam int LIM_W   = 7;
	localparam int NPTS_W  = 11;
	localparam int DIMS_W  = 5;
	localparam int CFG_W   = 11;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE    = 2'd2;

	typedef enum logic [1:0] {
		FN_LOAD_COORD = 2'd0,
		FN_LOAD_PARAM = 2'd1,
		FN_PAIR       = 2'd2,
		FN_CLEAR      = 2'd3
	} func_t;

	// per point parameters held in one memory word
	typedef struct packed {
		logic [RAD_W-1:0]  radius;
		logic [NORM_W-1:0] norm;
		logic [BETA_W-1:0] beta;
	} param_t;

	// divider request
	typedef struct packed {
		logic              start;
		logic [EXP_W-1:0]  dividend;
		logic [NORM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [AFF_W-1:0] quot;
	} div_rsp_t;

	// round(2^32 * exp(-2^k)) for k = -16 .. 4, indexed from 0
	function automatic logic [31:0] exp_coef(input logic [K_W-1:0] k);
		logic [31:0] c;
		case (k)
			5'd0:  c = 32'd4294901760;
			5'd1:  c = 32'd4294836226;
			5'd2:  c = 32'd4294705160;
			5'd3:  c = 32'd4294443040;
			5'd4:  c = 32'd4293918848;
			5'd5:  c = 32'd4292870656;
			5'd6:  c = 32'd4290775039;
			5'd7:  c = 32'd4286586875;
			5'd8:  c = 32'd4278222805;
			5'd9:  c = 32'd4261543595;
			5'd10: c = 32'd4228380000;
			5'd11: c = 32'd4162825044;
			5'd12: c = 32'd4034748382;
			5'd13: c = 32'd3790295335;
			5'd14: c = 32'd3344923893;
			5'd15: c = 32'd2605029347;
			5'd16: c = 32'd1580030169;
			5'd17: c = 32'd581260615;
			5'd18: c = 32'd78665070;
			5'd19: c = 32'd1440801;
			5'd20: c = 32'd483;
			default: c = 32'd0;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/spa_if.sv
// spa_in_if / spa_out_if: valid/ready channels for input and result transactions
// depends on spa_pkg

interface spa_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    func;
	logic [spa_pkg::PT_W-1:0]      point_a;
	logic [spa_pkg::PT_W-1:0]      point_b;
	logic [spa_pkg::DIM_W-1:0]     dim_index;
	logic signed [spa_pkg::COORD_W-1:0] coord_value;
	logic [spa_pkg::BETA_W-1:0]    beta_value;
	logic [spa_pkg::NORM_W-1:0]    norm_value;
	logic [spa_pkg::RAD_W-1:0]     radius_value;

	modport source(output valid, func, point_a, point_b, dim_index, coord_value,
		beta_value, norm_value, radius_value, input ready);
	modport sink(input valid, func, point_a, point_b, dim_index, coord_value,
		beta_value, norm_value, radius_value, output ready);
endinterface

interface spa_out_if;
	logic                       valid;
	logic                       ready;
	logic [spa_pkg::PT_W-1:0]   row_point;
	logic [spa_pkg::SLOT_W-1:0] slot;
	logic [spa_pkg::PT_W-1:0]   neighbor_point;
	logic [spa_pkg::AFF_W-1:0]  affinity;
	logic [spa_pkg::TOT_W-1:0]  total;
	logic                       last;

	modport source(output valid, row_point, slot, neighbor_point, affinity, total, last,
		input ready);
	modport sink(input valid, row_point, slot, neighbor_point, affinity, total, last,
		output ready);
endinterface

// File: rtl/spa_ram.sv
// spa_ram: generic single write, single read RAM with registered read data
// no dependencies

module spa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/spa_mul.sv
// spa_mul: shared 32x32 unsigned multiplier with registered product
// no dependencies

module spa_mul (
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [63:0] prod_q
);

	// one multiply per cycle, product available in the next cycle
	always_ff @(posedge clk) begin
		prod_q <= 64'(op_a) * 64'(op_b);
	end

endmodule

// File: rtl/spa_div.sv
// spa_div: restoring divider, one quotient bit a cycle, saturating quotient
// depends on spa_pkg

module spa_div (
	input  logic              clk,
	input  logic              arst_n,
	input  spa_pkg::div_req_t req,
	output spa_pkg::div_rsp_t rsp
);

	localparam int STEP_W = $clog2(spa_pkg::EXP_W + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [spa_pkg::EXP_W-1:0]   num_q;
	logic [spa_pkg::EXP_W-1:0]   quot_q;
	logic [spa_pkg::EXP_W-1:0]   rem_q;
	logic [spa_pkg::NORM_W-1:0]  den_q;
	logic [spa_pkg::EXP_W:0]     trial;
	logic [spa_pkg::EXP_W:0]     den_ext;
	logic                        fits;

	// trial subtraction of one step
	always_comb begin
		trial   = {rem_q, num_q[spa_pkg::EXP_W-1]};
		den_ext = (spa_pkg::EXP_W+1)'(den_q);
		fits    = trial >= den_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				num_q  <= req.dividend;
				rem_q  <= '0;
				quot_q <= '0;
				// a zero normaliser counts as one
				den_q  <= (req.divisor == '0) ? spa_pkg::NORM_W'(1) : req.divisor;
			end else if (busy_q) begin
				num_q  <= {num_q[spa_pkg::EXP_W-2:0], 1'b0};
				quot_q <= {quot_q[spa_pkg::EXP_W-2:0], fits};
				rem_q  <= fits ? spa_pkg::EXP_W'(trial - den_ext) : trial[spa_pkg::EXP_W-1:0];
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(spa_pkg::EXP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// saturate the quotient to the affinity width
	assign rsp = '{done: done_q,
		quot: quot_q[spa_pkg::EXP_W-1] ? '1 : quot_q[spa_pkg::AFF_W-1:0]};

endmodule

// File: rtl/sparse_pair_affinity_unit.sv
// Pair item: squared distance over the D dims in use, then per side beta times distance, exponent
// multiplies for the set bits of t past the first (none on a side whose product reaches 32.0), and a divide.
// Uses the shared multiplier and 33-step bit-serial divider; loads write on acceptance; ready only while idle.
// A clear item and reset each sweep the count memory, accepting no item meanwhile.
// Reset (arst_n low, asynchronous) clears control, total and configuration to defaults.
// depends on spa_pkg, spa_if, spa_ram, spa_mul, spa_div

module sparse_pair_affinity_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	spa_in_if.sink                        in_ch,
	spa_out_if.source                     out_ch,
	input  logic                          cfg_wr_en,
	input  logic [spa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spa_pkg::CFG_W-1:0]     cfg_wdata
);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DRA, S_DRB, S_DSUB, S_DACC, S_PRA, S_PRB, S_PCB,
		S_XM0, S_XM1, S_XM2, S_XK, S_XKW, S_DIV, S_DIVW, S_DEC, S_WA, S_WB
	} state_t;

	localparam int CA_W = spa_pkg::PT_W + spa_pkg::DIM_W;

	state_t                          st_q;
	logic [spa_pkg::LIM_W-1:0]       lim_cfg_q;
	logic [spa_pkg::NPTS_W-1:0]      npts_cfg_q;
	logic [spa_pkg::DIMS_W-1:0]      dims_cfg_q;
	logic [spa_pkg::PT_W-1:0]        a_q, b_q, clr_q;
	logic [spa_pkg::DIMS_W-1:0]      v_q;
	logic [spa_pkg::DIST_W-1:0]      l_q;
	logic [spa_pkg::COORD_W-1:0]     ca_q;
	spa_pkg::param_t                 pa_q, pb_q;
	logic [spa_pkg::CNT_W-1:0]       cnta_q, cntb_q;
	logic                            side_q, cb_q;
	logic [63:0]                     plo_q;
	logic [spa_pkg::T_W-1:0]         t_q;
	logic [spa_pkg::EXP_W-1:0]       e_q;
	logic [spa_pkg::K_W-1:0]         k_q;
	logic [spa_pkg::AFF_W-1:0]       aff_q;
	logic [spa_pkg::TOT_W-1:0]       total_q;
	logic                            out_valid_q;

	logic                            in_acc;
	logic [CA_W-1:0]                 coord_raddr;
	logic [spa_pkg::COORD_W-1:0]     coord_rd;
	spa_pkg::param_t                 param_wd, param_rd;
	logic [spa_pkg::PT_W-1:0]        pt_raddr;
	logic                            cnt_we;
	logic [spa_pkg::PT_W-1:0]        cnt_waddr;
	logic [spa_pkg::CNT_W-1:0]       cnt_wdata, cnt_rd;
	logic [31:0]                     mul_a, mul_b;
	logic [63:0]                     prod;
	spa_pkg::div_req_t               div_req;
	spa_pkg::div_rsp_t               div_rsp;
	logic signed [spa_pkg::COORD_W:0] diff;
	logic [spa_pkg::COORD_W:0]       mag;
	logic [64:0]                     h;
	logic [spa_pkg::BETA_W-1:0]      beta_cur;
	logic [spa_pkg::NORM_W-1:0]      norm_cur;
	logic [spa_pkg::NPTS_W-1:0]      npts;
	logic [spa_pkg::LIM_W-1:0]       lim;
	logic [spa_pkg::DIMS_W-1:0]      dims;
	logic                            ca_c, cb_c, emit_a, emit_b;
	logic [spa_pkg::TOT_W:0]         tot_sum;
	logic [spa_pkg::TOT_W-1:0]       tot_next;
	logic [spa_pkg::AFF_W:0]         aff_sum;
	logic                            pair_bad;

	// effective configuration
	always_comb begin
		npts = (npts_cfg_q > spa_pkg::NPTS_W'(spa_pkg::MAX_POINTS)) ?
			spa_pkg::NPTS_W'(spa_pkg::MAX_POINTS) : npts_cfg_q;
		lim  = (lim_cfg_q > spa_pkg::LIM_W'(spa_pkg::MAX_NEIGHBORS)) ?
			spa_pkg::LIM_W'(spa_pkg::MAX_NEIGHBORS) : lim_cfg_q;
		dims = (dims_cfg_q > spa_pkg::DIMS_W'(spa_pkg::MAX_DIM)) ?
			spa_pkg::DIMS_W'(spa_pkg::MAX_DIM) : dims_cfg_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_cfg_q  <= spa_pkg::LIM_W'(64);
			npts_cfg_q <= spa_pkg::NPTS_W'(1024);
			dims_cfg_q <= spa_pkg::DIMS_W'(16);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				spa_pkg::CFG_NEIGHBOR_LIMIT: lim_cfg_q  <= cfg_wdata[spa_pkg::LIM_W-1:0];
				spa_pkg::CFG_POINT_COUNT:    npts_cfg_q <= cfg_wdata[spa_pkg::NPTS_W-1:0];
				spa_pkg::CFG_DIMS_IN_USE:    dims_cfg_q <= cfg_wdata[spa_pkg::DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (st_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// coordinate, parameter and count memories
	assign coord_raddr = {(st_q == S_DRA) ? a_q : b_q, v_q[spa_pkg::DIM_W-1:0]};

	spa_ram #(.WIDTH(spa_pkg::COORD_W), .DEPTH(spa_pkg::MAX_POINTS * spa_pkg::MAX_DIM))
	u_coord_ram (
		.clk   (clk),
		.we    (in_acc && (in_ch.func == spa_pkg::FN_LOAD_COORD)),
		.waddr ({in_ch.point_a, in_ch.dim_index}),
		.wdata (in_ch.coord_value),
		.raddr (coord_raddr),
		.rdata (coord_rd)
	);

	assign param_wd = '{radius: in_ch.radius_value, norm: in_ch.norm_value,
		beta: in_ch.beta_value};
	assign pt_raddr = (st_q == S_PRA) ? a_q : b_q;

	spa_ram #(.WIDTH($bits(spa_pkg::param_t)), .DEPTH(spa_pkg::MAX_POINTS)) u_param_ram (
		.clk   (clk),
		.we    (in_acc && (in_ch.func == spa_pkg::FN_LOAD_PARAM)),
		.waddr (in_ch.point_a),
		.wdata (param_wd),
		.raddr (pt_raddr),
		.rdata (param_rd)
	);

	// count memory write: clearing sweep or an emitted entry
	always_comb begin
		ca_c   = (l_q <= pa_q.radius) && (cnta_q < lim);
		cb_c   = (l_q <= pb_q.radius) && (cntb_q < lim);
		emit_a = (st_q == S_DEC) && ca_c;
		emit_b = ((st_q == S_DEC) && !ca_c && cb_c) ||
			((st_q == S_WA) && out_ch.ready && cb_q);
		cnt_we    = (st_q == S_CLR) || emit_a || emit_b;
		cnt_waddr = (st_q == S_CLR) ? clr_q : (emit_a ? a_q : b_q);
		cnt_wdata = (st_q == S_CLR) ? '0 : (emit_a ? cnta_q + 1'b1 : cntb_q + 1'b1);
	end

	spa_ram #(.WIDTH(spa_pkg::CNT_W), .DEPTH(spa_pkg::MAX_POINTS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (pt_raddr),
		.rdata (cnt_rd)
	);

	// shared multiplier operand selection, divider request, sums and pair check
	always_comb begin
		diff     = $signed({ca_q[spa_pkg::COORD_W-1], ca_q}) -
			$signed({coord_rd[spa_pkg::COORD_W-1], coord_rd});
		mag      = diff[spa_pkg::COORD_W] ? (spa_pkg::COORD_W+1)'(-diff) :
			(spa_pkg::COORD_W+1)'(diff);
		beta_cur = side_q ? pb_q.beta : pa_q.beta;
		norm_cur = side_q ? pb_q.norm : pa_q.norm;
		case (st_q)
			S_DSUB: begin
				mul_a = 32'(mag[spa_pkg::COORD_W-1:0]);
				mul_b = 32'(mag[spa_pkg::COORD_W-1:0]);
			end
			S_XM0: begin
				mul_a = beta_cur;
				mul_b = l_q[31:0];
			end
			S_XM1: begin
				mul_a = beta_cur;
				mul_b = 32'(l_q[spa_pkg::DIST_W-1:32]);
			end
			S_XK: begin
				mul_a = e_q[31:0];
				mul_b = spa_pkg::exp_coef(k_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		h        = 65'(prod) + 65'(plo_q[63:32]);
		div_req  = '{start: (st_q == S_DIV), dividend: e_q, divisor: norm_cur};
		aff_sum  = (spa_pkg::AFF_W+1)'(aff_q) + (spa_pkg::AFF_W+1)'(div_rsp.quot);
		tot_sum  = (spa_pkg::TOT_W+1)'(total_q) + (spa_pkg::TOT_W+1)'(aff_q);
		tot_next = tot_sum[spa_pkg::TOT_W] ? '1 : tot_sum[spa_pkg::TOT_W-1:0];
		pair_bad = ({1'b0, in_ch.point_a} >= npts) || ({1'b0, in_ch.point_b} >= npts) ||
			(in_ch.point_a == in_ch.point_b);
	end

	spa_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod)
	);

	spa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			side_q      <= 1'b0;
			v_q         <= '0;
			k_q         <= '0;
			cb_q        <= 1'b0;
		end else begin
			case (st_q)
				// sweep the count memory to zero
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == spa_pkg::PT_W'(spa_pkg::MAX_POINTS - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						a_q <= in_ch.point_a;
						b_q <= in_ch.point_b;
						l_q <= '0;
						v_q <= '0;
						case (in_ch.func)
							spa_pkg::FN_CLEAR: begin
								total_q <= '0;
								clr_q   <= '0;
								st_q    <= S_CLR;
							end
							spa_pkg::FN_PAIR: begin
								if (!pair_bad) begin
									st_q <= (dims == '0) ? S_PRA : S_DRA;
								end
							end
							default: ;
						endcase
					end
				end
				// squared distance, one dimension per pass through DRA, DRB, DSUB and DACC
				S_DRA: st_q <= S_DRB;
				S_DRB: begin
					ca_q <= coord_rd;
					st_q <= S_DSUB;
				end
				S_DSUB: st_q <= S_DACC;
				S_DACC: begin
					l_q <= l_q + spa_pkg::DIST_W'(prod);
					v_q <= v_q + 1'b1;
					st_q <= (v_q + 1'b1 == dims) ? S_PRA : S_DRA;
				end
				// fetch point parameters and counts
				S_PRA: st_q <= S_PRB;
				S_PRB: begin
					pa_q   <= param_rd;
					cnta_q <= cnt_rd;
					st_q   <= S_PCB;
				end
				S_PCB: begin
					pb_q   <= param_rd;
					cntb_q <= cnt_rd;
					side_q <= 1'b0;
					st_q   <= S_XM0;
				end
				// beta times distance
				S_XM0: st_q <= S_XM1;
				S_XM1: begin
					plo_q <= prod;
					st_q  <= S_XM2;
				end
				S_XM2: begin
					k_q <= '0;
					if (|h[64:5]) begin
						e_q  <= '0;
						st_q <= S_DIV;
					end else begin
						t_q  <= {h[4:0], plo_q[31:16]};
						e_q  <= spa_pkg::EXP_W'(1) << 32;
						st_q <= S_XK;
					end
				end
				// exponential, one bit of t per step
				S_XK: begin
					if (k_q == spa_pkg::K_W'(spa_pkg::T_W)) begin
						st_q <= S_DIV;
					end else if (t_q[k_q]) begin
						if (e_q[32]) begin
							e_q <= spa_pkg::EXP_W'(spa_pkg::exp_coef(k_q));
							k_q <= k_q + 1'b1;
						end else begin
							st_q <= S_XKW;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_XKW: begin
					e_q  <= spa_pkg::EXP_W'(prod[63:32]);
					k_q  <= k_q + 1'b1;
					st_q <= S_XK;
				end
				S_DIV: st_q <= S_DIVW;
				S_DIVW: begin
					if (div_rsp.done) begin
						if (!side_q) begin
							aff_q  <= div_rsp.quot;
							side_q <= 1'b1;
							st_q   <= S_XM0;
						end else begin
							aff_q <= aff_sum[spa_pkg::AFF_W] ? '1 : aff_sum[spa_pkg::AFF_W-1:0];
							st_q  <= S_DEC;
						end
					end
				end
				// decide rows and emit results
				S_DEC: begin
					cb_q <= cb_c;
					if (ca_c) begin
						st_q <= S_WA;
					end else if (cb_c) begin
						st_q <= S_WB;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_WA: begin
					if (out_ch.ready) begin
						if (cb_q) begin
							st_q <= S_WB;
						end else begin
							out_valid_q <= 1'b0;
							st_q <= S_IDLE;
						end
					end
				end
				S_WB: begin
					if (out_ch.ready) begin
						out_valid_q <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase

			// output register load on an emitted entry
			if (emit_a || emit_b) begin
				out_valid_q           <= 1'b1;
				total_q               <= tot_next;
				out_ch.total          <= tot_next;
				out_ch.affinity       <= aff_q;
				out_ch.row_point      <= emit_a ? a_q : b_q;
				out_ch.neighbor_point <= emit_a ? b_q : a_q;
				out_ch.slot           <= emit_a ? cnta_q[spa_pkg::SLOT_W-1:0] :
					cntb_q[spa_pkg::SLOT_W-1:0];
				out_ch.last           <= emit_a ? !cb_c : 1'b1;
			end
		end
	end

	assign out_ch.valid = out_valid_q;

endmodule

// File: rtl/spa_checker.sv
// spa_checker: port-level assertions for the sparse pair affinity unit
// depends on the top level's ports; bound to sparse_pair_affinity_unit below

module spa_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);

	// a pending result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	// no input taken while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

	// an accepted item gives no result in the next cycle
	a_quiet_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result right after input transaction");

	// a non-final result is followed by another result
	a_more_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("missing second result of a pair");

	// the final result of a pair leaves the output empty
	a_empty_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("result after the final one of a pair");

endmodule

bind sparse_pair_affinity_unit spa_checker u_spa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_last  (out_ch.last)
);
